>>> sv/kpdc_pkg.sv
`default_nettype none

package kpdc_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int CFG_W          = 31;
    localparam int NOW_W          = 32;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int EVENT_W        = 2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(2);
    localparam logic [CFG_W-1:0] LONG_RST     = CFG_W'(300);
    localparam logic [CFG_W-1:0] LONGER_RST   = CFG_W'(1000);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONGER   = 2'd2;

    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SHORT  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LONG   = 2'd2;
    localparam logic [EVENT_W-1:0] EV_LONGER = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_PRESSING  = 3'd1,
        PH_PRESSED   = 3'd2,
        PH_LONG      = 3'd3,
        PH_LONGER    = 3'd4,
        PH_RELEASING = 3'd5
    } t_phase;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] long_t;
        logic [CFG_W-1:0] longer_t;
    } t_cfg;

endpackage

`default_nettype wire

>>> sv/kpdc_cfg_regs.sv
`default_nettype none

module kpdc_cfg_regs
    import kpdc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_DEBOUNCE: n_cfg.debounce = i_cfg_data;
                CFG_IDX_LONG:     n_cfg.long_t   = i_cfg_data;
                CFG_IDX_LONGER:   n_cfg.longer_t = i_cfg_data;
                default:          n_cfg          = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce <= DEBOUNCE_RST;
            r_cfg.long_t   <= LONG_RST;
            r_cfg.longer_t <= LONGER_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> sv/kpdc_in_stage.sv
`default_nettype none

module kpdc_in_stage
    import kpdc_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  i_key,
    input  wire logic [TIME_WIDTH-1:0] i_now,
    input  wire logic                  i_take,
    output logic                       o_ready,
    output logic                       o_valid,
    output logic                       o_key,
    output logic [TIME_WIDTH-1:0]      o_now
);

    logic                  r_valid;
    logic                  r_key;
    logic [TIME_WIDTH-1:0] r_now;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_key <= i_key;
            r_now <= i_now;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_now   = r_now;

endmodule

`default_nettype wire

>>> sv/kpdc_fsm.sv
`default_nettype none

module kpdc_fsm
    import kpdc_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic                  i_key,
    input  wire logic [TIME_WIDTH-1:0] i_now,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_out_ready,
    output logic                       o_take,
    output logic                       o_valid,
    output logic [EVENT_W-1:0]         o_event
);

    t_phase                r_phase;
    t_phase                n_phase;
    logic [TIME_WIDTH-1:0] r_mark;
    logic [TIME_WIDTH-1:0] n_mark;
    logic                  r_out_valid;
    logic [EVENT_W-1:0]    r_event;
    logic [EVENT_W-1:0]    n_event;
    logic                  stamp;

    logic [TIME_WIDTH-1:0] db_span;
    logic [TIME_WIDTH-1:0] long_span;
    logic [TIME_WIDTH-1:0] longer_span;
    logic [TIME_WIDTH-1:0] d_db;
    logic [TIME_WIDTH-1:0] d_long;
    logic [TIME_WIDTH-1:0] d_longer;
    logic                  after_db;
    logic                  after_long;
    logic                  after_longer;
    logic                  down;

    generate
        if (TIME_WIDTH > CFG_W) begin : g_span_ext
            assign db_span     = {{(TIME_WIDTH-CFG_W){1'b0}}, i_cfg.debounce};
            assign long_span   = {{(TIME_WIDTH-CFG_W){1'b0}}, i_cfg.long_t};
            assign longer_span = {{(TIME_WIDTH-CFG_W){1'b0}}, i_cfg.longer_t};
        end else begin : g_span_cut
            assign db_span     = i_cfg.debounce[TIME_WIDTH-1:0];
            assign long_span   = i_cfg.long_t[TIME_WIDTH-1:0];
            assign longer_span = i_cfg.longer_t[TIME_WIDTH-1:0];
        end
    endgenerate

    assign d_db     = i_now - r_mark - db_span;
    assign d_long   = i_now - r_mark - long_span;
    assign d_longer = i_now - r_mark - longer_span;

    assign after_db     = (d_db != '0) && !d_db[TIME_WIDTH-1];
    assign after_long   = (d_long != '0) && !d_long[TIME_WIDTH-1];
    assign after_longer = (d_longer != '0) && !d_longer[TIME_WIDTH-1];

    assign down   = !i_key;
    assign o_take = i_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (down) n_phase = PH_PRESSING;
            end
            PH_PRESSING: begin
                if (down && after_db) n_phase = PH_PRESSED;
            end
            PH_PRESSED: begin
                if (!down) n_phase = PH_RELEASING;
                else if (after_long) n_phase = PH_LONG;
            end
            PH_LONG: begin
                if (down && after_longer) n_phase = PH_LONGER;
                else if (!down && after_db) n_phase = PH_IDLE;
            end
            PH_LONGER: begin
                if (!down && after_db) n_phase = PH_IDLE;
            end
            PH_RELEASING: begin
                if (!down && after_db) n_phase = PH_IDLE;
            end
            default: n_phase = r_phase;
        endcase
    end

    always_comb begin
        n_event = EV_NONE;
        stamp   = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                stamp = down;
            end
            PH_PRESSING: begin
                stamp = down && after_db;
            end
            PH_PRESSED: begin
                if (!down) stamp = 1'b1;
                else if (after_long) n_event = EV_LONG;
            end
            PH_LONG: begin
                if (down && after_longer) n_event = EV_LONGER;
            end
            PH_RELEASING: begin
                if (!down && after_db) n_event = EV_SHORT;
            end
            default: begin
                n_event = EV_NONE;
                stamp   = 1'b0;
            end
        endcase
        n_mark = stamp ? i_now : r_mark;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_mark      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase <= n_phase;
                r_mark  <= n_mark;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_event <= n_event;
        end
    end

    assign o_valid = r_out_valid;
    assign o_event = r_event;

endmodule

`default_nettype wire

>>> sv/key_press_duration_classifier_top.sv
// Key press duration classifier.
// Each slave-side transfer carries one poll of an active-low key and the
// current tick time; every poll yields exactly one master-side transfer with
// an event code: none, short press, long press or longer press.
// Polls are debounced on press and on release, and all hold times are
// measured from the debounced press with wrap-aware time comparisons.
// The user must write the configuration registers (debounce, long and longer
// hold times) through the plain write port only while no poll is in flight;
// the block itself does not enforce this. A poll accepted into the input
// register is taken through the phase logic into the result register once
// the result register is empty or being read. Throughput is one poll per
// cycle while the receiver takes every result, as the phase and timestamp
// registers are updated for each poll taken.
// When the receiver stalls, the result register holds its transfer and the
// input register takes at most one further poll before tready falls.
// Synchronous active-low reset returns the phase to idle, clears the
// timestamp, empties both registers and reloads the default hold times.
`default_nettype none

module key_press_duration_classifier_top
    import kpdc_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // [0] key_level, [32:1] now, [39:33] zero
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // [1:0] event_res, [7:2] zero
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_data
);

    t_cfg                  cfg;
    logic [NOW_W-1:0]      port_now;
    logic [TIME_WIDTH-1:0] now_tw;
    logic                  st_valid;
    logic                  st_key;
    logic [TIME_WIDTH-1:0] st_now;
    logic                  take;
    logic [EVENT_W-1:0]    ev;

    assign port_now = i_s_axis_tdata[NOW_W:1];

    generate
        if (TIME_WIDTH > NOW_W) begin : g_now_ext
            assign now_tw = {{(TIME_WIDTH-NOW_W){1'b0}}, port_now};
        end else begin : g_now_cut
            assign now_tw = port_now[TIME_WIDTH-1:0];
        end
    endgenerate

    kpdc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    kpdc_in_stage #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_key   (i_s_axis_tdata[0]),
        .i_now   (now_tw),
        .i_take  (take),
        .o_ready (o_s_axis_tready),
        .o_valid (st_valid),
        .o_key   (st_key),
        .o_now   (st_now)
    );

    kpdc_fsm #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (st_valid),
        .i_key       (st_key),
        .i_now       (st_now),
        .i_cfg       (cfg),
        .i_out_ready (i_m_axis_tready),
        .o_take      (take),
        .o_valid     (o_m_axis_tvalid),
        .o_event     (ev)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W-EVENT_W){1'b0}}, ev};

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import kpdc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;
    localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS = 35;
    localparam int RANDOM_PHASES = 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_valid = 1'b0;
    logic [IN_TDATA_W-1:0] s_data = '0;
    logic m_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    wire o_s_axis_tready;
    wire o_m_axis_tvalid;
    wire [OUT_TDATA_W-1:0] o_m_axis_tdata;

    key_press_duration_classifier_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    // Shadow of the classifier state and its hold-time registers.
    t_phase ph_q = PH_IDLE;
    logic [NOW_W-1:0] stamp_q = '0;
    logic [CFG_W-1:0] debounce_r = DEBOUNCE_RST;
    logic [CFG_W-1:0] long_r = LONG_RST;
    logic [CFG_W-1:0] longer_r = LONGER_RST;

    logic [EVENT_W-1:0] pending_events[$];
    logic [EVENT_W-1:0] want_event;
    int mismatches = 0;
    int sent_items = 0;
    logic [NOW_W-1:0] tick_now = '0;

    bit gaps_on = 1'b1;
    bit rx_idle_on = 1'b1;
    logic hold_active = 1'b0;
    int rx_stall_left = 0;
    int hold_count = 0;
    event hold_go;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 40) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    function automatic bit is_past(input logic [NOW_W-1:0] t, input logic [NOW_W-1:0] base,
                                   input logic [CFG_W-1:0] span);
        logic [NOW_W-1:0] d;
        d = t - base - {1'b0, span};
        return (d != '0) && !d[NOW_W-1];
    endfunction

    function automatic logic [EVENT_W-1:0] classify_poll(input logic key_up,
                                                         input logic [NOW_W-1:0] t);
        logic [EVENT_W-1:0] ev;
        ev = EV_NONE;
        if (!key_up) begin
            case (ph_q)
                PH_IDLE: begin
                    ph_q = PH_PRESSING;
                    stamp_q = t;
                end
                PH_PRESSING: begin
                    if (is_past(t, stamp_q, debounce_r)) begin
                        ph_q = PH_PRESSED;
                        stamp_q = t;
                    end
                end
                PH_PRESSED: begin
                    if (is_past(t, stamp_q, long_r)) begin
                        ph_q = PH_LONG;
                        ev = EV_LONG;
                    end
                end
                PH_LONG: begin
                    if (is_past(t, stamp_q, longer_r)) begin
                        ph_q = PH_LONGER;
                        ev = EV_LONGER;
                    end
                end
                default: ;
            endcase
        end else begin
            case (ph_q)
                PH_PRESSED: begin
                    ph_q = PH_RELEASING;
                    stamp_q = t;
                end
                PH_RELEASING: begin
                    if (is_past(t, stamp_q, debounce_r)) begin
                        ph_q = PH_IDLE;
                        ev = EV_SHORT;
                    end
                end
                PH_LONG, PH_LONGER: begin
                    if (is_past(t, stamp_q, debounce_r)) begin
                        ph_q = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
        return ev;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, event_res=%0d",
                                          o_m_axis_tdata[EVENT_W-1:0]));
            end else begin
                want_event = pending_events.pop_front();
                if (o_m_axis_tdata[EVENT_W-1:0] !== want_event) begin
                    report_mismatch($sformatf("event_res=%0d, predicted %0d",
                                              o_m_axis_tdata[EVENT_W-1:0], want_event));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_active) begin
            m_ready <= 1'b0;
        end else if (rx_stall_left != 0) begin
            m_ready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            rx_stall_left <= $urandom_range(0, 5);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // The receiver refuses every transfer for a long stretch once asked to.
    always begin
        @(hold_go);
        @(posedge i_clk);
        hold_active <= 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
            @(posedge i_clk);
            hold_count++;
        end
        hold_active <= 1'b0;
    end

    task automatic send_poll(input logic key_up, input logic [NOW_W-1:0] t);
        s_valid <= 1'b1;
        s_data <= {{(IN_TDATA_W - NOW_W - 1){1'b0}}, t, key_up};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_events.push_back(classify_poll(key_up, t));
        sent_items++;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_IDX_DEBOUNCE: debounce_r = val;
            CFG_IDX_LONG:     long_r = val;
            CFG_IDX_LONGER:   longer_r = val;
            default: ;
        endcase
    endtask

    task automatic set_hold_times(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                                  input logic [CFG_W-1:0] lngr);
        drain();
        write_reg(CFG_IDX_DEBOUNCE, deb);
        write_reg(CFG_IDX_LONG, lng);
        write_reg(CFG_IDX_LONGER, lngr);
    endtask

    function automatic logic [NOW_W-1:0] tick_step();
        if ($urandom_range(0, 29) == 0) begin
            return $urandom();
        end
        return $urandom_range(0, 10);
    endfunction

    task automatic press_sequence;
        int n_down;
        int n_up;
        n_down = $urandom_range(1, 25);
        n_up = $urandom_range(1, 8);
        repeat (n_down) begin
            tick_now += tick_step();
            send_poll(1'b0, tick_now);
            if ($urandom_range(0, 12) == 0) begin
                send_poll(1'b1, tick_now + $urandom_range(0, 2));
            end
        end
        repeat (n_up) begin
            tick_now += tick_step();
            send_poll(1'b1, tick_now);
            if ($urandom_range(0, 12) == 0) begin
                send_poll(1'b0, tick_now + $urandom_range(0, 2));
            end
        end
    endtask

    task automatic noise_burst;
        repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 1) == 0) begin
                send_poll(1'($urandom_range(0, 1)), $urandom());
            end else begin
                send_poll(1'($urandom_range(0, 1)), tick_now + $urandom_range(0, 4));
            end
        end
    endtask

    // Default hold times: bounce on press and release, exact thresholds, the
    // long and longer events, release out of both, wrap of the tick counter
    // and half-range time jumps.
    task automatic test_directed;
        send_poll(1'b0, 32'hFFFF_FFF0);
        send_poll(1'b1, 32'hFFFF_FFF1);
        send_poll(1'b0, 32'hFFFF_FFF2);
        send_poll(1'b0, 32'hFFFF_FFF3);
        send_poll(1'b1, 32'hFFFF_FFF4);
        send_poll(1'b0, 32'hFFFF_FFFF);
        send_poll(1'b1, 32'h0000_0006);
        send_poll(1'b0, 32'd100);
        send_poll(1'b0, 32'd103);
        send_poll(1'b0, 32'd403);
        send_poll(1'b0, 32'd404);
        send_poll(1'b0, 32'd1103);
        send_poll(1'b0, 32'd1104);
        send_poll(1'b0, 32'd5000);
        send_poll(1'b1, 32'd5001);
        send_poll(1'b0, 32'd6000);
        send_poll(1'b0, 32'd6003);
        send_poll(1'b0, 32'd6304);
        send_poll(1'b1, 32'd6305);
        send_poll(1'b1, 32'h0000_0000);
        send_poll(1'b1, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'h0000_0000);
        send_poll(1'b0, 32'h8000_0000);
        send_poll(1'b0, 32'h0000_0000);
        send_poll(1'b1, 32'h0000_0001);
    endtask

    // Zero and full-scale hold times, plus a write to the unused index.
    task automatic test_config_extremes;
        logic [NOW_W-1:0] t;
        set_hold_times('0, '0, '0);
        t = 32'h1234_5678;
        send_poll(1'b0, t);
        send_poll(1'b0, t);
        send_poll(1'b0, t + 1);
        send_poll(1'b0, t + 1);
        send_poll(1'b0, t + 2);
        send_poll(1'b0, t + 3);
        send_poll(1'b1, t + 4);
        send_poll(1'b1, t + 5);

        set_hold_times(CFG_MAX, CFG_MAX, CFG_MAX);
        drain();
        write_reg(CFG_IDX_NONE, '0);
        t = 32'hF000_0000;
        send_poll(1'b0, t);
        send_poll(1'b0, t + 32'h7FFF_FFFF);
        send_poll(1'b0, t + 32'h8000_0000);
        t = t + 32'h8000_0000;
        send_poll(1'b0, t + 32'h7FFF_FFFF);
        send_poll(1'b0, t + 32'h8000_0000);
        send_poll(1'b0, t + 32'h8000_0000);
        send_poll(1'b1, t + 32'h8000_0000);
        set_hold_times(DEBOUNCE_RST, LONG_RST, LONGER_RST);
    endtask

    // The receiver stops for a long stretch while polls keep coming, so the
    // pipeline fills and the input side has to stall.
    task automatic test_backpressure;
        int i;
        set_hold_times(CFG_W'(1), CFG_W'(5), CFG_W'(20));
        gaps_on = 1'b0;
        ->hold_go;
        for (i = 0; i < 24; i++) begin
            tick_now += $urandom_range(0, 3);
            send_poll(i >= 18, tick_now);
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_random;
        int k;
        int budget;
        logic [CFG_W-1:0] deb;
        logic [CFG_W-1:0] lng;
        logic [CFG_W-1:0] lngr;
        for (k = 0; k < RANDOM_PHASES; k++) begin
            deb = CFG_W'($urandom_range(0, 6));
            lng = CFG_W'($urandom_range(0, 40));
            lngr = CFG_W'($urandom_range(0, 80));
            if ($urandom_range(0, 4) == 0) deb = CFG_W'($urandom());
            if ($urandom_range(0, 4) == 0) lng = CFG_W'($urandom());
            if ($urandom_range(0, 4) == 0) lngr = CFG_W'($urandom());
            set_hold_times(deb, lng, lngr);
            if (k == RANDOM_PHASES - 1) begin
                gaps_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            tick_now = $urandom();
            budget = sent_items + PHASE_ITEMS;
            while (sent_items < budget) begin
                if ($urandom_range(0, 6) == 0) begin
                    noise_burst();
                end else begin
                    press_sequence();
                end
            end
        end
    endtask

    initial begin
        int guard;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();

        s_valid <= 1'b0;
        guard = 0;
        while (pending_events.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_events.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_events.size()));
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
